/* rtl/vpa_pkg.sv */
// vpa_pkg: shared types and constants for the partition allocator
// depends on nothing
package vpa_pkg;
  localparam int POOL_SIZE_DEF  = 32768;
  localparam int MAX_BLOCKS_DEF = 32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADH    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] POL_WORST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_FIRST  = 2'd2;

  localparam logic [0:0] FN_ALLOC   = 1'b0;
  localparam logic [0:0] FN_RELEASE = 1'b1;

  localparam logic CFG_POLICY    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // one table entry: start and length, 17 bits each so pool sizes up to 64k fit
  typedef struct packed {
    logic [16:0] start;
    logic [16:0] len;
  } blk_t;

  // shift commands handed to every cell of a table
  typedef enum logic [2:0] {
    SH_HOLD, SH_LOAD_BLK, SH_REMOVE, SH_INSERT, SH_RESET
  } sh_op_t;

  typedef struct packed {
    sh_op_t      op;
    logic [8:0]  idx;
    blk_t        blk;
  } sh_ctl_t;
endpackage

/* rtl/vpa_cell.sv */
// vpa_cell: one entry of a block table; takes its neighbors' entries on shifts
// depends on vpa_pkg
module vpa_cell
  import vpa_pkg::*;
#(
  parameter int POS = 0,
  parameter int RST_START = 0,
  parameter int RST_LEN = 0
) (
  input  logic    clk,
  input  sh_ctl_t ctl,
  input  blk_t    left_blk,
  input  blk_t    right_blk,
  output blk_t    blk
);
  always_ff @(posedge clk) begin
    case (ctl.op)
      SH_LOAD_BLK: if (32'(ctl.idx) == POS) blk <= ctl.blk;
      SH_REMOVE:   if (32'(ctl.idx) <= POS) blk <= right_blk;
      SH_INSERT: begin
        if (32'(ctl.idx) == POS) blk <= ctl.blk;
        else if (32'(ctl.idx) < POS) blk <= left_blk;
      end
      SH_RESET: begin
        blk.start <= 17'(RST_START);
        blk.len   <= 17'(RST_LEN);
      end
      default: blk <= blk;
    endcase
  end
endmodule

/* rtl/vpa_table.sv */
// vpa_table: a row of vpa_cell entries forming one shifting table
// depends on vpa_pkg, vpa_cell
module vpa_table
  import vpa_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int RST_LEN = 0
) (
  input  logic    clk,
  input  sh_ctl_t ctl,
  output blk_t    ent [DEPTH]
);
  blk_t zero_blk;
  assign zero_blk = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    vpa_cell #(
      .POS(g), .RST_START(0), .RST_LEN(g == 0 ? RST_LEN : 0)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .left_blk((g == 0) ? zero_blk : ent[(g == 0) ? 0 : g - 1]),
      .right_blk((g == DEPTH - 1) ? zero_blk : ent[(g == DEPTH - 1) ? g : g + 1]),
      .blk(ent[g])
    );
  end
endmodule

/* rtl/variable_partition_allocator.sv */
// variable_partition_allocator: top level, sequencer over two shifting tables
// depends on vpa_pkg, vpa_table, vpa_cell
//
//  channel | ports                                          | handshake
//  in      | func request_size handle                        | start & !busy
//  out     | status block_address block_length free/used_blocks | done, one cycle
//  cfg     | cfg_we cfg_index cfg_data                        | cfg_we
//
// an accepted item runs a scan step per table entry whatever the fill, then the
// S_UPD table update (followed by S_UPD2 when a release merges both neighbors)
// and the closing S_DONE step; an item refused at accept or finding no fit
// skips the update and goes from the scan straight to S_DONE
// busy drops in the result cycle, so the next item can be taken at its end
// after reset the S_INIT state loads the initial tables; start is held off meanwhile
// the result is shown for one cycle with done; it cannot be stalled
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int POOL_SIZE  = POOL_SIZE_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  func,
  input  logic [15:0] request_size,
  input  logic [5:0]  handle,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [14:0] block_address,
  output logic [15:0] block_length,
  output logic [5:0]  free_blocks,
  output logic [5:0]  used_blocks
);
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_UPD, S_UPD2, S_DONE} state_t;

  state_t      state;
  logic [1:0]  fit_policy;
  logic [15:0] split_threshold;
  logic [0:0]  fn;
  logic [16:0] req;
  logic [IW-1:0] fcnt, ucnt, k;
  logic [IW-1:0] best, left, right, ins;
  logic        have_best, have_left, have_right;
  blk_t        rel;
  logic [IW-1:0] uidx, uidx_in;
  sh_ctl_t     fctl, uctl;
  blk_t        fent [MAX_BLOCKS];
  blk_t        uent [MAX_BLOCKS];
  blk_t        fk, fb, fl, fr;
  logic [16:0] rel_end, rem;

  vpa_table #(.DEPTH(MAX_BLOCKS), .RST_LEN(POOL_SIZE)) u_free (
    .clk(clk), .ctl(fctl), .ent(fent));
  vpa_table #(.DEPTH(MAX_BLOCKS), .RST_LEN(0)) u_used (
    .clk(clk), .ctl(uctl), .ent(uent));

  assign busy = (state != S_IDLE);
  assign fk   = fent[k[AW-1:0]];
  assign fb   = fent[best[AW-1:0]];
  assign fl   = fent[left[AW-1:0]];
  assign fr   = fent[right[AW-1:0]];
  assign rel_end = rel.start + rel.len;
  assign rem  = fb.len - req;
  assign uidx_in = ucnt - IW'(handle);

  logic split_ok;
  assign split_ok = (rem != 17'd0) && (rem >= {1'b0, split_threshold});

  // table commands come from the sequencer state
  always_comb begin
    fctl = '{op: SH_HOLD, idx: '0, blk: '0};
    uctl = '{op: SH_HOLD, idx: '0, blk: '0};
    if (state == S_INIT) begin
      fctl.op = SH_RESET;
      uctl.op = SH_RESET;
    end else if (state == S_UPD && fn == FN_ALLOC) begin
      uctl = '{op: SH_LOAD_BLK, idx: 9'(ucnt), blk: '{start: fb.start,
               len: split_ok ? req : fb.len}};
      if (split_ok)
        fctl = '{op: SH_LOAD_BLK, idx: 9'(best),
                 blk: '{start: fb.start + req, len: rem}};
      else
        fctl = '{op: SH_REMOVE, idx: 9'(best), blk: '0};
    end else if (state == S_UPD && fn == FN_RELEASE) begin
      uctl = '{op: SH_REMOVE, idx: 9'(uidx), blk: '0};
      if (have_left && have_right)
        fctl = '{op: SH_LOAD_BLK, idx: 9'(left), blk: '{start: fl.start,
                 len: fl.len + rel.len + fr.len}};
      else if (have_left)
        fctl = '{op: SH_LOAD_BLK, idx: 9'(left), blk: '{start: fl.start,
                 len: fl.len + rel.len}};
      else if (have_right)
        fctl = '{op: SH_LOAD_BLK, idx: 9'(right), blk: '{start: rel.start,
                 len: fr.len + rel.len}};
      else
        fctl = '{op: SH_INSERT, idx: 9'(ins), blk: rel};
    end else if (state == S_UPD2) begin
      fctl = '{op: SH_REMOVE, idx: 9'(right), blk: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fit_policy <= POL_FIRST;
      split_threshold <= '0;
      fcnt <= IW'(1);
      ucnt <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY) fit_policy <= cfg_data[1:0];
        else split_threshold <= cfg_data;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: if (start) begin
          fn <= func; req <= {1'b0, request_size};
          k <= '0; have_best <= 1'b0; have_left <= 1'b0; have_right <= 1'b0;
          best <= '0; left <= '0; right <= '0; ins <= fcnt;
          uidx <= uidx_in;
          rel <= uent[uidx_in[AW-1:0]];
          if (func == FN_ALLOC && request_size == 16'd0) status <= ST_NOFIT;
          else if (func == FN_ALLOC && 32'(ucnt) >= MAX_BLOCKS) status <= ST_FULL;
          else if (func == FN_RELEASE && (handle == 6'd0 || 32'(handle) > 32'(ucnt)))
            status <= ST_BADH;
          else status <= ST_OK;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (k < fcnt) begin
            if (fn == FN_ALLOC) begin
              if (fk.len >= req) begin
                if (!have_best) begin
                  have_best <= 1'b1; best <= k;
                end else if (fit_policy == POL_WORST && fk.len > fb.len) begin
                  best <= k;
                end else if (fit_policy == POL_BEST && fk.len < fb.len) begin
                  best <= k;
                end
              end
            end else begin
              if (fk.start + fk.len == rel.start) begin
                have_left <= 1'b1; left <= k;
              end
              if (fk.start == rel_end) begin
                have_right <= 1'b1; right <= k;
              end
              if (fk.start >= rel.start && ins == fcnt) ins <= k;
            end
          end
          k <= k + IW'(1);
          if (32'(k) == MAX_BLOCKS - 1) begin
            if (status != ST_OK) state <= S_DONE;
            else if (fn == FN_ALLOC && !have_best && !(k < fcnt && fk.len >= req)) begin
              status <= ST_NOFIT; state <= S_DONE;
            end else state <= S_UPD;
          end
        end
        S_UPD: begin
          if (fn == FN_ALLOC) begin
            if (!have_best) begin
              status <= ST_NOFIT; state <= S_DONE;
            end else begin
              block_address <= fb.start[14:0];
              block_length  <= split_ok ? req[15:0] : fb.len[15:0];
              ucnt <= ucnt + IW'(1);
              if (!split_ok) fcnt <= fcnt - IW'(1);
              state <= S_DONE;
            end
          end else if (!have_left && !have_right && 32'(fcnt) >= MAX_BLOCKS) begin
            status <= ST_FULL; state <= S_DONE;
          end else begin
            block_address <= rel.start[14:0];
            block_length  <= rel.len[15:0];
            ucnt <= ucnt - IW'(1);
            if (!have_left && !have_right) fcnt <= fcnt + IW'(1);
            if (have_left && have_right) begin
              fcnt <= fcnt - IW'(1); state <= S_UPD2;
            end else state <= S_DONE;
          end
        end
        S_UPD2: state <= S_DONE;
        S_DONE: begin
          if (status != ST_OK) begin
            block_address <= '0; block_length <= '0;
          end
          free_blocks <= 6'(fcnt);
          used_blocks <= 6'(ucnt);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe only follows the final sequencer step
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE) else $error("done without final step");
  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fcnt) <= MAX_BLOCKS && 32'(ucnt) <= MAX_BLOCKS) else $error("count overflow");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state != S_IDLE)) else $error("scan skipped to idle");
endmodule
